// ===== hw/rtl/sbpl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbpl_pkg
// Shared types and constants of the smallest-box point locator: field widths,
// item codes, the stored box layout and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package sbpl_pkg;

    localparam int COORD_W       = 16;   // Q8.8 coordinate width
    localparam int SLOT_W        = 8;    // node_slot / found_slot width
    localparam int CFG_W         = 9;    // nodes_in_use width
    localparam int DEF_MAX_NODES = 256;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // One table entry; index 0 is x, 1 is y, 2 is z
    typedef struct packed {
        logic [2:0][COORD_W-1:0] center;
        logic [2:0][COORD_W-1:0] extent;
    } box_t;

    typedef struct packed {
        logic                    op;
        logic [SLOT_W-1:0]       node_slot;
        logic [2:0][COORD_W-1:0] center;
        logic [2:0][COORD_W-1:0] extent;
        logic [2:0][COORD_W-1:0] point;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] found_slot;
        logic              was_inside;
    } rsp_t;

    typedef struct packed {
        logic wr_node;
        logic start_query;
        logic rd_en;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic pipe_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sbpl_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbpl_if
// Valid/ready channels of the locator: request beats in, response beats out.
// ----------------------------------------------------------------------------
interface sbpl_req_if
    import sbpl_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [SLOT_W-1:0]         node_slot;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [COORD_W-1:0]        extent_x;
    logic [COORD_W-1:0]        extent_y;
    logic [COORD_W-1:0]        extent_z;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;

    modport source (
        output valid, op, node_slot, center_x, center_y, center_z,
               extent_x, extent_y, extent_z, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, op, node_slot, center_x, center_y, center_z,
               extent_x, extent_y, extent_z, point_x, point_y, point_z,
        output ready
    );
endinterface

interface sbpl_rsp_if
    import sbpl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] found_slot;
    logic              was_inside;

    modport source (
        output valid, found_slot, was_inside,
        input  ready
    );
    modport sink (
        input  valid, found_slot, was_inside,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/sbpl_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbpl_datapath
// Node table memory, four-stage per-node evaluation pipeline (containment,
// squared distance, volume) and the running best-candidate registers.
// ----------------------------------------------------------------------------
module sbpl_datapath
    import sbpl_pkg::*;
#(
    parameter  int MAX_NODES = DEF_MAX_NODES,
    localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dp_cmd_t          cmd,
    input  wire logic [IDX_W-1:0] rd_addr,
    input  wire req_t             req_data,
    output dp_status_t            status,
    output rsp_t                  rsp_data
);

    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * COORD_W + 1;
    localparam int DIST_W = SQ_W + 2;
    localparam int VOL_W  = 3 * COORD_W;

    // Node table
    box_t box_mem [MAX_NODES];

    logic slot_ok;
    assign slot_ok = (32'(req_data.node_slot) < MAX_NODES);

    // Query point, latched at query start
    logic [2:0][COORD_W-1:0] point_reg;

    // Stage 1: table read
    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    box_t             s1_box_reg;

    // Stage 2: bounds test, centre offset, partial volume
    logic                           s2_valid_reg;
    logic [IDX_W-1:0]               s2_idx_reg;
    logic [2:0]                     s2_inside_reg;
    logic [2:0]                     s2_inside_next;
    logic signed [DIFF_W-1:0]       s2_diff_reg  [3];
    logic signed [DIFF_W-1:0]       s2_diff_next [3];
    logic [2*COORD_W-1:0]           s2_area_reg;
    logic [COORD_W-1:0]             s2_ez_reg;

    // Stage 3: squares and volume
    logic                 s3_valid_reg;
    logic [IDX_W-1:0]     s3_idx_reg;
    logic                 s3_inside_reg;
    logic [SQ_W-1:0]      s3_sq_reg  [3];
    logic [SQ_W-1:0]      s3_sq_next [3];
    logic [VOL_W-1:0]     s3_vol_reg;

    // Stage 4: summed distance
    logic                 s4_valid_reg;
    logic [IDX_W-1:0]     s4_idx_reg;
    logic                 s4_inside_reg;
    logic [DIST_W-1:0]    s4_dist_reg;
    logic [VOL_W-1:0]     s4_vol_reg;

    // Running best
    logic                 best_in_valid_reg;
    logic [IDX_W-1:0]     best_in_idx_reg;
    logic [VOL_W-1:0]     best_vol_reg;
    logic                 best_near_valid_reg;
    logic [IDX_W-1:0]     best_near_idx_reg;
    logic [DIST_W-1:0]    best_dist_reg;

    logic                 take_in;
    logic                 take_near;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_node && slot_ok)
        begin
            box_mem[IDX_W'(req_data.node_slot)] <= '{center: req_data.center,
                                                     extent: req_data.extent};
        end
        if (cmd.rd_en)
        begin
            s1_box_reg <= box_mem[rd_addr];
        end
    end

    always_comb
    begin : stage2_calc
        logic signed [COORD_W+1:0] c2;
        logic signed [COORD_W+1:0] p2;
        logic signed [COORD_W+1:0] s_ext;
        logic signed [COORD_W+1:0] lo;
        logic signed [COORD_W+1:0] hi;
        for (int a = 0; a < 3; a++)
        begin
            c2    = {s1_box_reg.center[a][COORD_W-1], s1_box_reg.center[a], 1'b0};
            p2    = {point_reg[a][COORD_W-1], point_reg[a], 1'b0};
            s_ext = {2'b00, s1_box_reg.extent[a]};
            lo    = c2 - s_ext;
            hi    = c2 + s_ext;
            s2_inside_next[a] = (p2 >= lo) && (p2 <= hi);
            s2_diff_next[a]   = $signed({s1_box_reg.center[a][COORD_W-1],
                                         s1_box_reg.center[a]})
                              - $signed({point_reg[a][COORD_W-1], point_reg[a]});
        end
    end

    always_comb
    begin : stage3_calc
        logic signed [2*DIFF_W-1:0] prod;
        for (int a = 0; a < 3; a++)
        begin
            prod          = s2_diff_reg[a] * s2_diff_reg[a];
            s3_sq_next[a] = prod[SQ_W-1:0];
        end
    end

    assign take_in   = s4_valid_reg && s4_inside_reg
                    && (!best_in_valid_reg || (s4_vol_reg < best_vol_reg));
    assign take_near = s4_valid_reg
                    && (!best_near_valid_reg || (s4_dist_reg < best_dist_reg));

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            point_reg <= req_data.point;
        end
        s1_idx_reg    <= rd_addr;

        s2_idx_reg    <= s1_idx_reg;
        s2_inside_reg <= s2_inside_next;
        s2_diff_reg   <= s2_diff_next;
        s2_area_reg   <= s1_box_reg.extent[0] * s1_box_reg.extent[1];
        s2_ez_reg     <= s1_box_reg.extent[2];

        s3_idx_reg    <= s2_idx_reg;
        s3_inside_reg <= &s2_inside_reg;
        s3_sq_reg     <= s3_sq_next;
        s3_vol_reg    <= s2_area_reg * s2_ez_reg;

        s4_idx_reg    <= s3_idx_reg;
        s4_inside_reg <= s3_inside_reg;
        s4_vol_reg    <= s3_vol_reg;
        s4_dist_reg   <= DIST_W'(s3_sq_reg[0]) + DIST_W'(s3_sq_reg[1])
                       + DIST_W'(s3_sq_reg[2]);

        if (take_in)
        begin
            best_vol_reg <= s4_vol_reg;
        end
        if (take_near)
        begin
            best_dist_reg <= s4_dist_reg;
        end

        if (cmd.load_out)
        begin
            rsp_data.found_slot <= best_in_valid_reg ? SLOT_W'(best_in_idx_reg)
                                                     : SLOT_W'(best_near_idx_reg);
            rsp_data.was_inside <= best_in_valid_reg;
        end
    end

    // Pipeline control and best-candidate bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            s2_valid_reg        <= 1'b0;
            s3_valid_reg        <= 1'b0;
            s4_valid_reg        <= 1'b0;
            best_in_valid_reg   <= 1'b0;
            best_in_idx_reg     <= '0;
            best_near_valid_reg <= 1'b0;
            best_near_idx_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= cmd.rd_en;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            if (cmd.start_query)
            begin
                // empty scan answers slot 0, not inside
                best_in_valid_reg   <= 1'b0;
                best_in_idx_reg     <= '0;
                best_near_valid_reg <= 1'b0;
                best_near_idx_reg   <= '0;
            end
            else
            begin
                if (take_in)
                begin
                    best_in_valid_reg <= 1'b1;
                    best_in_idx_reg   <= s4_idx_reg;
                end
                if (take_near)
                begin
                    best_near_valid_reg <= 1'b1;
                    best_near_idx_reg   <= s4_idx_reg;
                end
            end
        end
    end

    assign status.pipe_busy = s1_valid_reg | s2_valid_reg | s3_valid_reg | s4_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sbpl_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbpl_ctrl
// Sequencer of the locator: request handshake, scan address counter,
// pipeline drain, response valid and the nodes_in_use register.
// ----------------------------------------------------------------------------
module sbpl_ctrl
    import sbpl_pkg::*;
#(
    parameter  int MAX_NODES = DEF_MAX_NODES,
    localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    input  wire logic             req_op,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    output dp_cmd_t               cmd,
    output logic [IDX_W-1:0]      rd_addr,
    input  wire dp_status_t       status
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CFG_W-1:0]  nodes_in_use_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;

    logic              accept;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CMP_W-1:0]  cfg_ext;
    logic [CMP_W-1:0]  limit;
    logic [CNT_W-1:0]  scan_count;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign rd_addr   = cnt_reg[IDX_W-1:0];
    assign rsp_valid = rsp_valid_reg;

    // Clamp the scan to the table depth
    assign cfg_ext    = CMP_W'(nodes_in_use_reg);
    assign limit      = CMP_W'(MAX_NODES);
    assign scan_count = (cfg_ext > limit) ? CNT_W'(limit) : CNT_W'(cfg_ext);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        count_next       = count_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        cmd              = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_op == OP_WRITE)
                    begin
                        cmd.wr_node = 1'b1;
                    end
                    else
                    begin
                        cmd.start_query = 1'b1;
                        cnt_next        = '0;
                        count_next      = scan_count;
                        state_next      = (scan_count == '0) ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                cnt_next  = cnt_inc;
                if (cnt_inc == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            count_reg        <= '0;
            nodes_in_use_reg <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                nodes_in_use_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/smallest_box_point_locator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smallest_box_point_locator
// Finds the smallest stored 3D box holding a query point, else the box with
// the nearest centre.
// ----------------------------------------------------------------------------
// A write beat (op 0) stores one box, centre and full size in Q8.8, in table
// entry node_slot (if below MAX_NODES). A query beat (op 1) scans the first
// N = min(nodes_in_use, MAX_NODES) entries and returns one response beat:
// the entry with the smallest volume whose bounds (inclusive) hold the point
// with was_inside set, or else the entry whose centre is nearest by squared
// distance with was_inside clear; ties go to the lower index, and an empty
// scan answers slot 0, not inside. The table has one read port, so a query
// reads one entry per cycle into the four-stage evaluation pipeline and
// takes no new beat until the result is loaded. A finished response
// waits in an output register while the next beat is taken. Entries must be
// written before a query scans them; nodes_in_use must be written only while
// the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module smallest_box_point_locator
    import sbpl_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    sbpl_req_if.sink              req,
    sbpl_rsp_if.source            rsp,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data
);

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [IDX_W-1:0] rd_addr;
    req_t             req_data;
    rsp_t             rsp_data;

    assign req_data.op        = req.op;
    assign req_data.node_slot = req.node_slot;
    assign req_data.center    = {req.center_z, req.center_y, req.center_x};
    assign req_data.extent    = {req.extent_z, req.extent_y, req.extent_x};
    assign req_data.point     = {req.point_z, req.point_y, req.point_x};

    assign rsp.found_slot = rsp_data.found_slot;
    assign rsp.was_inside = rsp_data.was_inside;

    sbpl_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_op      (req_data.op),
        .req_ready   (req.ready),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .status      (status)
    );

    sbpl_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .req_data (req_data),
        .status   (status),
        .rsp_data (rsp_data)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the smallest-box point locator. Box writes fill the
// node table, query beats look up points; a scoreboard keeps its own copy of
// the table and the scan count and predicts each response (smallest holding
// box, else nearest centre, lowest index on ties). Directed corner cases run
// first, then random traffic under three send/receive idling patterns and a
// range of scan counts from 0 to 511.
// ----------------------------------------------------------------------------
module tb_top
    import sbpl_pkg::*;
();

    localparam int  SETTLE    = 12;         // cycles for a trailing write to land
    localparam int  PHASE_LEN = 86;         // random beats per scan-count setting
    localparam int  MAX_PRINT = 40;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the node table plus the queue of expected picks
    // ------------------------------------------------------------------------
    class slot_pick_board;
        logic signed [COORD_W-1:0] box_ctr [DEF_MAX_NODES][3];
        logic        [COORD_W-1:0] box_ext [DEF_MAX_NODES][3];
        int unsigned               scan_count;
        rsp_t                      expected_picks [$];
        int                        mismatches;
        int                        writes_seen;
        int                        queries_seen;
        int                        inside_hits;
        int                        nearest_picks;

        function new();
            scan_count    = 0;
            mismatches    = 0;
            writes_seen   = 0;
            queries_seen  = 0;
            inside_hits   = 0;
            nearest_picks = 0;
        endfunction

        // Smallest holding box, else nearest centre; lowest index wins ties
        function rsp_t pick_slot(logic [2:0][COORD_W-1:0] pt);
            int unsigned               n;
            logic signed [COORD_W-1:0] pc;
            longint                    c, s, p, d;
            longint unsigned           vol, sq_dist, best_vol, best_dist;
            bit                        have_in, in_box;
            int                        best_in, best_near;
            rsp_t                      r;
            n         = (scan_count > DEF_MAX_NODES) ? DEF_MAX_NODES : scan_count;
            have_in   = 0;
            best_in   = 0;
            best_near = 0;
            best_vol  = 0;
            best_dist = 0;
            for (int i = 0; i < n; i++)
            begin
                in_box  = 1;
                sq_dist = 0;
                for (int a = 0; a < 3; a++)
                begin
                    pc = pt[a];
                    p  = longint'(pc);
                    c  = longint'(box_ctr[i][a]);
                    s  = longint'(box_ext[i][a]);
                    // doubled coordinates keep the half-size bound exact
                    if (2 * p < 2 * c - s || 2 * p > 2 * c + s)
                        in_box = 0;
                    d       = c - p;
                    sq_dist = sq_dist + unsigned'(d * d);
                end
                if (in_box)
                begin
                    vol = longint'(box_ext[i][0]) * longint'(box_ext[i][1])
                        * longint'(box_ext[i][2]);
                    if (!have_in || vol < best_vol)
                    begin
                        have_in  = 1;
                        best_vol = vol;
                        best_in  = i;
                    end
                end
                if (i == 0 || sq_dist < best_dist)
                begin
                    best_dist = sq_dist;
                    best_near = i;
                end
            end
            r.found_slot = have_in ? best_in[SLOT_W-1:0] : best_near[SLOT_W-1:0];
            r.was_inside = have_in;
            return r;
        endfunction

        function void note_beat(req_t b);
            if (b.op == OP_WRITE)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    box_ctr[b.node_slot][a] = b.center[a];
                    box_ext[b.node_slot][a] = b.extent[a];
                end
                writes_seen++;
            end
            else
            begin
                expected_picks = {expected_picks, pick_slot(b.point)};
                queries_seen++;
            end
        endfunction

        task report(string msg);
            mismatches++;
            // cap the log on a badly broken block, keep counting
            if (mismatches <= MAX_PRINT)
                $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_answer(logic [SLOT_W-1:0] got_slot, logic got_inside);
            rsp_t want;
            if (expected_picks.size() == 0)
            begin
                report($sformatf("response slot %0d inside %0b with no query pending",
                                 got_slot, got_inside));
                return;
            end
            want = expected_picks.pop_front();
            if (want.was_inside)
                inside_hits++;
            else
                nearest_picks++;
            if (got_slot !== want.found_slot)
                report($sformatf("found_slot %0d, want %0d", got_slot, want.found_slot));
            if (got_inside !== want.was_inside)
                report($sformatf("was_inside %0b, want %0b (slot %0d)",
                                 got_inside, want.was_inside, want.found_slot));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels, block
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_W-1:0]     cfg_wr_data;
    int unsigned          send_idle_pct;
    int unsigned          rsp_idle_pct;
    int                   settings_done;
    bit                   written [DEF_MAX_NODES];
    slot_pick_board       board = new();

    sbpl_req_if req_ch ();
    sbpl_rsp_if rsp_ch ();

    smallest_box_point_locator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Response side: random back-pressure, checked at the rising edge
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_answer(rsp_ch.found_slot, rsp_ch.was_inside);

    // ------------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------------
    function automatic logic [COORD_W-1:0] to_coord(int v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[COORD_W-1:0];
    endfunction

    function automatic req_t box_beat(int slot, int cx, int cy, int cz,
                                      int ex, int ey, int ez);
        req_t b;
        b.op        = OP_WRITE;
        b.node_slot = slot[SLOT_W-1:0];
        b.center[0] = cx[COORD_W-1:0];
        b.center[1] = cy[COORD_W-1:0];
        b.center[2] = cz[COORD_W-1:0];
        b.extent[0] = ex[COORD_W-1:0];
        b.extent[1] = ey[COORD_W-1:0];
        b.extent[2] = ez[COORD_W-1:0];
        // point fields are don't-care on a write: fill them with noise
        for (int a = 0; a < 3; a++)
            b.point[a] = COORD_W'($urandom);
        return b;
    endfunction

    function automatic req_t point_beat(int px, int py, int pz);
        req_t b;
        b.op        = OP_QUERY;
        b.node_slot = SLOT_W'($urandom);
        for (int a = 0; a < 3; a++)
        begin
            b.center[a] = COORD_W'($urandom);
            b.extent[a] = COORD_W'($urandom);
        end
        b.point[0] = to_coord(px);
        b.point[1] = to_coord(py);
        b.point[2] = to_coord(pz);
        return b;
    endfunction

    function automatic req_t random_box_beat(int slot);
        req_t b;
        int   src, r, e;
        b   = box_beat(slot, 0, 0, 0, 0, 0, 0);
        src = $urandom_range(DEF_MAX_NODES - 1);
        if ($urandom_range(9) == 0 && written[src])
        begin
            // copy an existing box to force volume and distance ties
            for (int a = 0; a < 3; a++)
            begin
                b.center[a] = board.box_ctr[src][a];
                b.extent[a] = board.box_ext[src][a];
            end
            return b;
        end
        for (int a = 0; a < 3; a++)
        begin
            if ($urandom_range(9) < 7)
                b.center[a] = to_coord(int'($urandom_range(4095)) - 2048);
            else
                b.center[a] = COORD_W'($urandom);
            r = $urandom_range(99);
            if (r < 40)
                e = $urandom_range(1023);
            else if (r < 70)
                e = $urandom_range(8191);
            else if (r < 85)
                e = $urandom_range(65535);
            else if (r < 95)
                e = 0;
            else
                e = 65535;
            b.extent[a] = e[COORD_W-1:0];
        end
        return b;
    endfunction

    // Points mostly land in or on the faces of a scanned box
    function automatic req_t query_beat(int n);
        int          k, r, c, h;
        int          p [3];
        r = $urandom_range(99);
        k = (n > 0) ? $urandom_range(n - 1) : 0;
        for (int a = 0; a < 3; a++)
        begin
            if (n == 0 || r >= 85)
                p[a] = int'($urandom_range(65535)) - 32768;
            else
            begin
                c = int'(board.box_ctr[k][a]);
                h = int'(board.box_ext[k][a]) / 2;
                if (r < 60)
                    p[a] = c + int'($urandom_range(2 * h + 2)) - (h + 1);
                else
                    // on the bound, or one step past it
                    p[a] = c + ($urandom_range(1) ? 1 : -1) * (h + int'($urandom_range(1)));
            end
        end
        return point_beat(p[0], p[1], p[2]);
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_beat(req_t b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.op        <= b.op;
        req_ch.node_slot <= b.node_slot;
        req_ch.center_x  <= b.center[0];
        req_ch.center_y  <= b.center[1];
        req_ch.center_z  <= b.center[2];
        req_ch.extent_x  <= b.extent[0];
        req_ch.extent_y  <= b.extent[1];
        req_ch.extent_z  <= b.extent[2];
        req_ch.point_x   <= b.point[0];
        req_ch.point_y   <= b.point[1];
        req_ch.point_z   <= b.point[2];
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (b.op == OP_WRITE)
            written[b.node_slot] = 1'b1;
        board.note_beat(b);
    endtask

    task automatic release_req();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic drain(int settle);
        while (board.expected_picks.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_scan_count(int unsigned v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[CFG_W-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        board.scan_count = v;
        settings_done++;
    endtask

    // Fill the scanned range, switch the scan count, then mixed traffic
    task automatic run_setting(int unsigned count, int beats);
        int n, hold_at, slot;
        n = (count > DEF_MAX_NODES) ? DEF_MAX_NODES : count;
        for (int i = 0; i < n; i++)
            if (!written[i])
                send_beat(random_box_beat(i));
        release_req();
        drain(SETTLE);
        write_scan_count(count);
        hold_at = $urandom_range(beats - 1);
        for (int i = 0; i < beats; i++)
        begin
            if (i == hold_at)
            begin
                release_req();
                drain(0);
            end
            if ($urandom_range(99) < 35)
            begin
                slot = (n > 0 && $urandom_range(1)) ? $urandom_range(n - 1)
                                                    : $urandom_range(DEF_MAX_NODES - 1);
                send_beat(random_box_beat(slot));
            end
            else
                send_beat(query_beat(n));
        end
        release_req();
        drain(SETTLE);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    int unsigned scan_plan [3][4] = '{'{1, 12, 40, 0},
                                      '{256, 3, 130, 511},
                                      '{300, 64, 2, 255}};

    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        req_ch.valid     = 1'b0;
        req_ch.op        = OP_WRITE;
        req_ch.node_slot = '0;
        req_ch.center_x  = '0;
        req_ch.center_y  = '0;
        req_ch.center_z  = '0;
        req_ch.extent_x  = '0;
        req_ch.extent_y  = '0;
        req_ch.extent_z  = '0;
        req_ch.point_x   = '0;
        req_ch.point_y   = '0;
        req_ch.point_z   = '0;
        send_idle_pct    = 11;
        rsp_idle_pct     = 87;
        settings_done    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table answers slot 0, not inside
        write_scan_count(0);
        send_beat(point_beat(-32768, -32768, -32768));
        send_beat(point_beat(32767, 32767, 32767));

        // degenerate corner box, maximal box, nested, duplicate, odd size, far tie
        send_beat(box_beat(0, -32768, -32768, -32768, 0, 0, 0));
        send_beat(box_beat(1, 32767, 32767, 32767, 65535, 65535, 65535));
        send_beat(box_beat(2, 100, 100, 100, 20, 20, 20));
        send_beat(box_beat(3, 100, 100, 100, 20, 20, 20));
        send_beat(box_beat(4, 105, 100, 100, 10, 10, 10));
        send_beat(box_beat(5, -1000, 0, 0, 3, 3, 3));
        send_beat(box_beat(6, -3000, 0, 0, 0, 0, 0));
        send_beat(box_beat(7, -3000, 0, 0, 0, 0, 0));
        release_req();
        drain(SETTLE);
        write_scan_count(8);
        send_beat(point_beat(-32768, -32768, -32768));
        send_beat(point_beat(110, 110, 110));
        send_beat(point_beat(90, 90, 90));
        send_beat(point_beat(0, 0, 0));
        send_beat(point_beat(-1, 0, 0));
        send_beat(point_beat(-2000, 0, 0));
        send_beat(point_beat(-999, 0, 0));
        send_beat(point_beat(-998, 0, 0));
        send_beat(point_beat(32767, 32767, 32767));
        release_req();
        drain(SETTLE);
        write_scan_count(1);
        send_beat(point_beat(32767, 32767, 32767));
        release_req();
        drain(SETTLE);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 11;
                    rsp_idle_pct  = 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    rsp_idle_pct  = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rsp_idle_pct  = 0;
                end
            endcase
            for (int s = 0; s < 4; s++)
                run_setting(scan_plan[ph][s], PHASE_LEN);
        end

        release_req();
        drain(SETTLE);
        $display("covered %0d box writes and %0d point queries over %0d scan-count settings",
                 board.writes_seen, board.queries_seen, settings_done);
        $display("queries resolved: %0d by a holding box, %0d by nearest centre",
                 board.inside_hits, board.nearest_picks);
        if (board.mismatches == 0)
            $display("[smallest_box_point_locator] OK");
        else
            $display("[smallest_box_point_locator] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #48000000;
        $display("TIMEOUT: %0d responses still pending", board.expected_picks.size());
        $display("[smallest_box_point_locator] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
